[hdl/voxel_piece_movability_top_assert.svh]
`ifndef VOXEL_PIECE_MOVABILITY_TOP_ASSERT_SVH
`define VOXEL_PIECE_MOVABILITY_TOP_ASSERT_SVH

// cause implies effect in the same cycle
`define VPM_ASSERT_NOW(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error("vpm check failed");

// cause implies effect in the next cycle
`define VPM_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("vpm check failed");

`endif

[hdl/vpm_pkg.sv]
package vpm_pkg;

  localparam int DIM_BITS   = 4;
  localparam int MAX_DIM    = 1 << DIM_BITS;
  localparam int EXT_W      = DIM_BITS + 1;
  localparam int SIZE_W     = 5;
  localparam int PIECE_BITS = 8;
  localparam int ADDR_W     = 3 * DIM_BITS;
  localparam int CELLS      = 1 << ADDR_W;
  localparam int CMP_W      = (SIZE_W > EXT_W) ? SIZE_W : EXT_W;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_NBR   = 2'd2;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  localparam logic [1:0] PASS_X = 2'd0;
  localparam logic [1:0] PASS_Y = 2'd1;
  localparam logic [1:0] PASS_Z = 2'd2;

  localparam logic [2:0] DIR_PX = 3'd0;
  localparam logic [2:0] DIR_NX = 3'd1;
  localparam logic [2:0] DIR_PY = 3'd2;
  localparam logic [2:0] DIR_NY = 3'd3;
  localparam logic [2:0] DIR_PZ = 3'd4;
  localparam logic [2:0] DIR_NZ = 3'd5;

  typedef struct packed {
    logic clear_step;
    logic do_write;
    logic latch;
    logic start_scan;
    logic start_nbr;
    logic load_out;
  } vpm_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic nbr_done;
    logic empty_grid;
    logic out_free;
  } vpm_sts_t;

endpackage

[hdl/voxel_piece_movability_top.sv]
// Grid of 16x16x16 piece numbers in one block RAM. After reset a clearing
// pass zeroes the RAM, one cell a cycle, so no command is taken until every
// cell is cleared. A write to an in-range cell is stored as it is accepted.
// A neighbour query makes six RAM reads, one per direction. A movability
// query scans the in-range grid three times, once with each axis as the fast
// one, one cell a cycle through the single read port. Only one query is worked
// on at a time; a finished answer waits in the output register while the next
// command may be taken.
module voxel_piece_movability_top import vpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            command,
  input  logic [DIM_BITS-1:0]   pos_x,
  input  logic [DIM_BITS-1:0]   pos_y,
  input  logic [DIM_BITS-1:0]   pos_z,
  input  logic [PIECE_BITS-1:0] cell_value,
  input  logic [PIECE_BITS-1:0] piece_id,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  answer_kind,
  output logic [2:0]            free_direction,
  output logic [5:0]            blocked_mask,
  output logic                  all_blocked,
  output logic                  bad_piece,
  output logic [PIECE_BITS-1:0] highest_piece,
  output logic [2:0]            neighbour_count,
  output logic [2:0]            exterior_faces
);

  vpm_cmd_t cmd;
  vpm_sts_t sts;

  vpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .command   (command),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  vpm_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .command         (command),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .cell_value      (cell_value),
    .piece_id        (piece_id),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .answer_kind     (answer_kind),
    .free_direction  (free_direction),
    .blocked_mask    (blocked_mask),
    .all_blocked     (all_blocked),
    .bad_piece       (bad_piece),
    .highest_piece   (highest_piece),
    .neighbour_count (neighbour_count),
    .exterior_faces  (exterior_faces)
  );

endmodule

[hdl/vpm_ram.sv]
module vpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/vpm_ctrl.sv]
module vpm_ctrl import vpm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] command,
  output logic       req_stall,
  input  vpm_sts_t   sts,
  output vpm_cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_NBR   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          case (command)
            CMD_WRITE: cmd.do_write = 1'b1;
            CMD_MOVE: begin
              cmd.start_scan = 1'b1;
              state_next = sts.empty_grid ? ST_DONE : ST_SCAN;
            end
            CMD_NBR: begin
              cmd.start_nbr = 1'b1;
              state_next = ST_NBR;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_NBR: begin
        if (sts.nbr_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `include "voxel_piece_movability_top_assert.svh"

  `VPM_ASSERT_NOW(a_accept_idle, accept, !sts.clear_done || state == ST_IDLE)
  `VPM_ASSERT_NEXT(a_scan_to_done, state == ST_SCAN && sts.scan_done, state == ST_DONE)
  `VPM_ASSERT_NEXT(a_nbr_to_done, state == ST_NBR && sts.nbr_done, state == ST_DONE)
  `VPM_ASSERT_NEXT(a_no_reclear, accept, state != ST_CLEAR)

endmodule

[hdl/vpm_datapath.sv]
module vpm_datapath import vpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  vpm_cmd_t              cmd,
  output vpm_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data,
  input  logic [1:0]            command,
  input  logic [DIM_BITS-1:0]   pos_x,
  input  logic [DIM_BITS-1:0]   pos_y,
  input  logic [DIM_BITS-1:0]   pos_z,
  input  logic [PIECE_BITS-1:0] cell_value,
  input  logic [PIECE_BITS-1:0] piece_id,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  answer_kind,
  output logic [2:0]            free_direction,
  output logic [5:0]            blocked_mask,
  output logic                  all_blocked,
  output logic                  bad_piece,
  output logic [PIECE_BITS-1:0] highest_piece,
  output logic [2:0]            neighbour_count,
  output logic [2:0]            exterior_faces
);

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [EXT_W-1:0]  ex, ey, ez;

  logic [1:0]            lcmd;
  logic [DIM_BITS-1:0]   lx, ly, lz;
  logic [PIECE_BITS-1:0] lpiece;

  logic [ADDR_W-1:0]     clr_cnt;
  logic                  ram_we;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [PIECE_BITS-1:0] wdata, rdata;

  // scan issue side
  logic                scanning;
  logic [1:0]          pass;
  logic [DIM_BITS-1:0] c_in, c_mid, c_out;
  logic [DIM_BITS-1:0] sx, sy, sz;
  logic [EXT_W-1:0]    e_in, e_mid, e_out;
  logic                end_in, end_mid, end_out, end_all;

  // scan data side
  logic       rd_vld, rd_first, rd_last;
  logic [1:0] rd_pass;
  logic       seen_p, seen_h, sp_eff, sh_eff, is_p, is_h;
  logic [5:0] mask;
  logic [PIECE_BITS-1:0] highest;

  // neighbour side
  logic             nbr_run;
  logic [2:0]       nd;
  logic [EXT_W-1:0] nx, ny, nz;
  logic             n_in;
  logic             nb_vld, nb_in, nb_last;
  logic [2:0]       ncount;

  logic [2:0] dir;

  function automatic logic [EXT_W-1:0] sat(input logic [SIZE_W-1:0] s);
    return (CMP_W'(s) > CMP_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : EXT_W'(s);
  endfunction

  assign ex = sat(size_x);
  assign ey = sat(size_y);
  assign ez = sat(size_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_W'(MAX_DIM);
      size_y <= SIZE_W'(MAX_DIM);
      size_z <= SIZE_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lcmd   <= command;
      lx     <= pos_x;
      ly     <= pos_y;
      lz     <= pos_z;
      lpiece <= piece_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_comb begin
    case (pass)
      PASS_X: begin
        sx = c_in; sy = c_mid; sz = c_out;
        e_in = ex; e_mid = ey; e_out = ez;
      end
      PASS_Y: begin
        sy = c_in; sx = c_mid; sz = c_out;
        e_in = ey; e_mid = ex; e_out = ez;
      end
      default: begin
        sz = c_in; sy = c_mid; sx = c_out;
        e_in = ez; e_mid = ey; e_out = ex;
      end
    endcase
  end

  assign end_in  = EXT_W'(c_in) == e_in - 1'b1;
  assign end_mid = EXT_W'(c_mid) == e_mid - 1'b1;
  assign end_out = EXT_W'(c_out) == e_out - 1'b1;
  assign end_all = end_in && end_mid && end_out;

  always_comb begin
    case (nd)
      DIR_PX:  begin nx = EXT_W'(lx) + 1'b1; ny = EXT_W'(ly); nz = EXT_W'(lz); end
      DIR_NX:  begin nx = EXT_W'(lx) - 1'b1; ny = EXT_W'(ly); nz = EXT_W'(lz); end
      DIR_PY:  begin nx = EXT_W'(lx); ny = EXT_W'(ly) + 1'b1; nz = EXT_W'(lz); end
      DIR_NY:  begin nx = EXT_W'(lx); ny = EXT_W'(ly) - 1'b1; nz = EXT_W'(lz); end
      DIR_PZ:  begin nx = EXT_W'(lx); ny = EXT_W'(ly); nz = EXT_W'(lz) + 1'b1; end
      default: begin nx = EXT_W'(lx); ny = EXT_W'(ly); nz = EXT_W'(lz) - 1'b1; end
    endcase
  end

  assign n_in = (nx < ex) && (ny < ey) && (nz < ez);

  always_comb begin
    ram_we = 1'b0;
    waddr  = {pos_x, pos_y, pos_z};
    wdata  = cell_value;
    if (cmd.clear_step) begin
      ram_we = 1'b1;
      waddr  = clr_cnt;
      wdata  = '0;
    end else if (cmd.do_write) begin
      ram_we = (EXT_W'(pos_x) < ex) && (EXT_W'(pos_y) < ey) && (EXT_W'(pos_z) < ez);
    end
  end

  assign raddr = nbr_run ? {nx[DIM_BITS-1:0], ny[DIM_BITS-1:0], nz[DIM_BITS-1:0]}
                         : {sx, sy, sz};

  vpm_ram #(.WIDTH(PIECE_BITS), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      rd_vld   <= 1'b0;
      nbr_run  <= 1'b0;
      nb_vld   <= 1'b0;
    end else begin
      rd_vld <= scanning;
      nb_vld <= nbr_run;
      if (cmd.start_scan) begin
        scanning <= !sts.empty_grid;
      end else if (scanning && end_all && pass == PASS_Z) begin
        scanning <= 1'b0;
      end
      if (cmd.start_nbr) begin
        nbr_run <= 1'b1;
      end else if (nbr_run && nd == DIR_NZ) begin
        nbr_run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= (c_in == '0);
    rd_pass  <= pass;
    rd_last  <= end_all && pass == PASS_Z;
    nb_in    <= n_in;
    nb_last  <= (nd == DIR_NZ);
    if (cmd.start_scan) begin
      pass  <= PASS_X;
      c_in  <= '0;
      c_mid <= '0;
      c_out <= '0;
    end else if (scanning) begin
      c_in <= end_in ? '0 : c_in + 1'b1;
      if (end_in) begin
        c_mid <= end_mid ? '0 : c_mid + 1'b1;
        if (end_mid) begin
          c_out <= end_out ? '0 : c_out + 1'b1;
          if (end_out) begin
            pass <= pass + 1'b1;
          end
        end
      end
    end
    if (cmd.start_nbr) begin
      nd <= DIR_PX;
    end else if (nbr_run) begin
      nd <= nd + 1'b1;
    end
  end

  assign sp_eff = !rd_first && seen_p;
  assign sh_eff = !rd_first && seen_h;
  assign is_p   = (rdata == lpiece);
  assign is_h   = (rdata > lpiece);

  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      mask    <= '0;
      highest <= '0;
      seen_p  <= 1'b0;
      seen_h  <= 1'b0;
    end else if (rd_vld) begin
      seen_p <= sp_eff || is_p;
      seen_h <= sh_eff || is_h;
      if (rdata > highest) begin
        highest <= rdata;
      end
      // a higher cell ahead of the piece blocks the positive direction
      if (is_h && sp_eff) begin
        mask[{rd_pass, 1'b0}] <= 1'b1;
      end
      if (is_p && sh_eff) begin
        mask[{rd_pass, 1'b1}] <= 1'b1;
      end
    end
    if (cmd.start_nbr) begin
      ncount <= '0;
    end else if (nb_vld && nb_in && rdata != '0) begin
      ncount <= ncount + 1'b1;
    end
  end

  always_comb begin
    dir = DIR_NZ;
    for (int d = 5; d >= 0; d--) begin
      if (!mask[d]) begin
        dir = 3'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      answer_kind     <= 1'b0;
      free_direction  <= '0;
      blocked_mask    <= '0;
      all_blocked     <= 1'b0;
      bad_piece       <= 1'b0;
      highest_piece   <= '0;
      neighbour_count <= '0;
      exterior_faces  <= '0;
      if (lcmd == CMD_NBR) begin
        answer_kind     <= 1'b1;
        neighbour_count <= ncount;
        exterior_faces  <= 3'd6 - ncount;
      end else begin
        highest_piece <= highest;
        if (lpiece == '0) begin
          bad_piece <= 1'b1;
        end else begin
          free_direction <= dir;
          blocked_mask   <= mask;
          all_blocked    <= &mask;
        end
      end
    end
  end

  assign sts.clear_done = &clr_cnt;
  assign sts.scan_done  = rd_vld && rd_last;
  assign sts.nbr_done   = nb_vld && nb_last;
  assign sts.empty_grid = (ex == '0) || (ey == '0) || (ez == '0);
  assign sts.out_free   = !rsp_valid || !rsp_stall;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import vpm_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic [1:0]            command;
    logic [DIM_BITS-1:0]   pos_x, pos_y, pos_z;
    logic [PIECE_BITS-1:0] cell_value, piece_id;
  } grid_req_t;

  typedef struct {
    logic                  answer_kind;
    logic [2:0]            free_direction;
    logic [5:0]            blocked_mask;
    logic                  all_blocked, bad_piece;
    logic [PIECE_BITS-1:0] highest_piece;
    logic [2:0]            neighbour_count, exterior_faces;
  } grid_answer_t;

  class movability_scoreboard;
    logic [PIECE_BITS-1:0] cells [CELLS];
    logic [SIZE_W-1:0]     extent_reg [3];
    grid_answer_t          pending_answers [$];
    int                    errors, answers_seen, moves_seen;

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (extent_reg[i]) extent_reg[i] = 5'd16;
    endfunction

    function int ext(int a);
      return (extent_reg[a] > MAX_DIM) ? MAX_DIM : int'(extent_reg[a]);
    endfunction

    function bit in_grid(int x, int y, int z);
      return x >= 0 && y >= 0 && z >= 0 && x < ext(0) && y < ext(1) && z < ext(2);
    endfunction

    function int piece_at(int x, int y, int z);
      if (!in_grid(x, y, z)) return 0;
      return cells[(x * MAX_DIM + y) * MAX_DIM + z];
    endfunction

    function void set_extent(logic [1:0] idx, logic [SIZE_W-1:0] v);
      extent_reg[idx] = v;
    endfunction

    function bit ray_hits(int x, int y, int z, int d, int own);
      int lim, dx, dy, dz;
      lim = ext(0);
      if (ext(1) > lim) lim = ext(1);
      if (ext(2) > lim) lim = ext(2);
      dx = (d == DIR_PX) ? 1 : (d == DIR_NX) ? -1 : 0;
      dy = (d == DIR_PY) ? 1 : (d == DIR_NY) ? -1 : 0;
      dz = (d == DIR_PZ) ? 1 : (d == DIR_NZ) ? -1 : 0;
      for (int i = 0; i < lim; i++) begin
        x += dx; y += dy; z += dz;
        if (piece_at(x, y, z) > own) return 1;
      end
      return 0;
    endfunction

    function void note_transfer(grid_req_t r);
      grid_answer_t a;
      int n, top;
      logic [5:0] mask;
      a = '{default: '0};
      case (r.command)
        CMD_WRITE: begin
          if (in_grid(r.pos_x, r.pos_y, r.pos_z))
            cells[(int'(r.pos_x) * MAX_DIM + r.pos_y) * MAX_DIM + r.pos_z] = r.cell_value;
        end
        CMD_NBR: begin
          n = 0;
          n += piece_at(r.pos_x + 1, r.pos_y, r.pos_z) != 0;
          n += piece_at(r.pos_x - 1, r.pos_y, r.pos_z) != 0;
          n += piece_at(r.pos_x, r.pos_y + 1, r.pos_z) != 0;
          n += piece_at(r.pos_x, r.pos_y - 1, r.pos_z) != 0;
          n += piece_at(r.pos_x, r.pos_y, r.pos_z + 1) != 0;
          n += piece_at(r.pos_x, r.pos_y, r.pos_z - 1) != 0;
          a.answer_kind = 1'b1;
          a.neighbour_count = 3'(n);
          a.exterior_faces = 3'(6 - n);
          pending_answers = {pending_answers, a};
        end
        CMD_MOVE: begin
          top = 0;
          mask = '0;
          for (int x = 0; x < ext(0); x++)
            for (int y = 0; y < ext(1); y++)
              for (int z = 0; z < ext(2); z++) begin
                if (piece_at(x, y, z) > top) top = piece_at(x, y, z);
                if (r.piece_id != 0 && piece_at(x, y, z) == r.piece_id)
                  for (int d = 0; d < 6; d++)
                    if (!mask[d] && ray_hits(x, y, z, d, int'(r.piece_id))) mask[d] = 1'b1;
              end
          a.highest_piece = PIECE_BITS'(top);
          if (r.piece_id == 0) a.bad_piece = 1'b1;
          else begin
            a.free_direction = DIR_NZ;
            for (int d = 5; d >= 0; d--) if (!mask[d]) a.free_direction = 3'(d);
            a.blocked_mask = mask;
            a.all_blocked = &mask;
          end
          pending_answers = {pending_answers, a};
        end
        default: ;
      endcase
    endfunction

    function void check_answer(grid_answer_t g);
      grid_answer_t e;
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("answer transfer with nothing pending");
        errors++;
        return;
      end
      e = pending_answers.pop_front();
      if (!e.answer_kind) moves_seen++;
      if (g.answer_kind !== e.answer_kind) begin
        $error("answer_kind exp %0d got %0d", e.answer_kind, g.answer_kind); errors++;
      end
      if (g.free_direction !== e.free_direction) begin
        $error("free_direction exp %0d got %0d", e.free_direction, g.free_direction); errors++;
      end
      if (g.blocked_mask !== e.blocked_mask) begin
        $error("blocked_mask exp %0h got %0h", e.blocked_mask, g.blocked_mask); errors++;
      end
      if (g.all_blocked !== e.all_blocked) begin
        $error("all_blocked exp %0d got %0d", e.all_blocked, g.all_blocked); errors++;
      end
      if (g.bad_piece !== e.bad_piece) begin
        $error("bad_piece exp %0d got %0d", e.bad_piece, g.bad_piece); errors++;
      end
      if (g.highest_piece !== e.highest_piece) begin
        $error("highest_piece exp %0d got %0d", e.highest_piece, g.highest_piece); errors++;
      end
      if (g.neighbour_count !== e.neighbour_count) begin
        $error("neighbour_count exp %0d got %0d", e.neighbour_count, g.neighbour_count);
        errors++;
      end
      if (g.exterior_faces !== e.exterior_faces) begin
        $error("exterior_faces exp %0d got %0d", e.exterior_faces, g.exterior_faces); errors++;
      end
    endfunction
  endclass

  logic                  clk, rst;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [SIZE_W-1:0]     cfg_data;
  logic                  req_valid, req_stall;
  logic [1:0]            command;
  logic [DIM_BITS-1:0]   pos_x, pos_y, pos_z;
  logic [PIECE_BITS-1:0] cell_value, piece_id;
  logic                  rsp_valid, rsp_stall;
  logic                  answer_kind;
  logic [2:0]            free_direction;
  logic [5:0]            blocked_mask;
  logic                  all_blocked, bad_piece;
  logic [PIECE_BITS-1:0] highest_piece;
  logic [2:0]            neighbour_count, exterior_faces;

  movability_scoreboard sb;
  bit  no_gaps, long_hold;
  int  idle_cycles, sent;

  voxel_piece_movability_top u_top (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 60000) begin
      $display("testbench failed");
      $finish;
    end
  end

  // answer side
  initial begin
    int k;
    grid_answer_t g;
    rsp_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      k = no_gaps ? 0 : $urandom_range(0, 14);
      if (long_hold) begin
        k = 800;
        long_hold = 0;
      end
      if (k > 0) begin
        @(negedge clk) rsp_stall <= 1'b1;
        repeat (k - 1) @(negedge clk);
      end
      @(negedge clk) rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      g.answer_kind = answer_kind;
      g.free_direction = free_direction;
      g.blocked_mask = blocked_mask;
      g.all_blocked = all_blocked;
      g.bad_piece = bad_piece;
      g.highest_piece = highest_piece;
      g.neighbour_count = neighbour_count;
      g.exterior_faces = exterior_faces;
      sb.check_answer(g);
    end
  end

  task automatic send(logic [1:0] c, int x, int y, int z, int v, int p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    repeat (gap) @(negedge clk) req_valid <= 1'b0;
    @(negedge clk);
    command <= c; pos_x <= x[3:0]; pos_y <= y[3:0]; pos_z <= z[3:0];
    cell_value <= v[7:0]; piece_id <= p[7:0];
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_transfer('{c, x[3:0], y[3:0], z[3:0], v[7:0], p[7:0]});
    sent++;
  endtask

  task automatic drain();
    @(negedge clk) req_valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_size(logic [1:0] idx, int v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= SIZE_W'(v);
    sb.set_extent(idx, SIZE_W'(v));
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic random_item(int sx, int sy, int sz);
    int r, x, y, z;
    logic [1:0] c;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) begin
      x = $urandom_range(0, 15); y = $urandom_range(0, 15); z = $urandom_range(0, 15);
    end else begin
      x = $urandom_range(0, sx - 1); y = $urandom_range(0, sy - 1);
      z = $urandom_range(0, sz - 1);
    end
    c = (r < 50) ? CMD_WRITE : (r < 72) ? CMD_MOVE : (r < 95) ? CMD_NBR : CMD_NONE;
    send(c, x, y, z,
         ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6),
         ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6));
  endtask

  initial begin
    int sx, sy, sz;
    sb = new();
    rst = 1'b1; cfg_we = 1'b0; cfg_index = REG_SIZE_X; cfg_data = '0;
    req_valid = 1'b0; command = CMD_WRITE;
    pos_x = '0; pos_y = '0; pos_z = '0; cell_value = '0; piece_id = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // full grid: blocking from above, top piece, zero piece, neighbour queries
    send(CMD_WRITE, 0, 0, 0, 5, 0);
    send(CMD_WRITE, 0, 0, 9, 9, 0);
    send(CMD_WRITE, 15, 15, 15, 255, 0);
    send(CMD_WRITE, 1, 0, 0, 3, 0);
    send(CMD_NBR, 0, 0, 1, 0, 0);
    send(CMD_NBR, 15, 15, 15, 0, 0);
    send(CMD_NONE, 15, 15, 15, 255, 255);
    send(CMD_MOVE, 0, 0, 0, 0, 5);
    send(CMD_MOVE, 0, 0, 0, 0, 0);
    send(CMD_MOVE, 0, 0, 0, 0, 255);
    drain();

    // degenerate and saturated extents
    set_size(REG_SIZE_X, 0); set_size(REG_SIZE_Y, 31); set_size(REG_SIZE_Z, 1);
    send(CMD_WRITE, 0, 3, 0, 7, 0);
    send(CMD_NBR, 0, 0, 0, 0, 0);
    send(CMD_MOVE, 0, 0, 0, 0, 7);
    drain();
    set_size(REG_SIZE_X, 2); set_size(REG_SIZE_Y, 1); set_size(REG_SIZE_Z, 2);
    send(CMD_WRITE, 0, 0, 0, 4, 0);
    send(CMD_WRITE, 0, 0, 1, 6, 0);
    send(CMD_WRITE, 1, 0, 0, 6, 0);
    send(CMD_WRITE, 1, 0, 1, 6, 0);
    send(CMD_MOVE, 0, 0, 0, 0, 4);
    send(CMD_MOVE, 0, 0, 0, 0, 200);
    send(CMD_NBR, 1, 1, 1, 0, 0);
    drain();

    // random phases on small grids
    for (int ph = 0; ph < 5; ph++) begin
      sx = $urandom_range(1, 5); sy = $urandom_range(1, 5); sz = $urandom_range(1, 5);
      set_size(REG_SIZE_X, sx); set_size(REG_SIZE_Y, sy); set_size(REG_SIZE_Z, sz);
      no_gaps = (ph == 1 || ph == 3);
      if (ph == 2) long_hold = 1;
      for (int i = 0; i < 24; i++) random_item(sx, sy, sz);
      no_gaps = 0;
      drain();
    end

    $display("%0d transfers sent, %0d answers checked (%0d movability)",
             sent, sb.answers_seen, sb.moves_seen);
    if (sb.errors == 0 && sb.pending_answers.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
